@@ src/cct_pkg.sv @@
package cct_pkg;

  // Field and datapath widths
  localparam int DATA_W = 24;
  localparam int PROD_W = 2 * DATA_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int ACC_W = 59;
  localparam int SUM_W = 60;
  localparam int DEG_W = 5;
  localparam int MAX_DEGREE = 31;
  localparam int CNT_W = $clog2((MAX_DEGREE + 1) * (MAX_DEGREE + 1) + 1);

  // Register file
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_LSB = 2;
  localparam logic REG_DEGREE = 1'b0;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified coefficient: six pair sums and the end-of-group mark
  typedef struct packed {
    logic                     last;
    logic signed [PAIR_W-1:0] vv;
    logic signed [PAIR_W-1:0] dd;
    logic signed [PAIR_W-1:0] ww;
    logic signed [PAIR_W-1:0] vd;
    logic signed [PAIR_W-1:0] vw;
    logic signed [PAIR_W-1:0] dw;
  } cct_entry_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } cct_qstat_t;

  // Coefficients per group: (degree+1)^2 with the degree clamped
  function automatic logic [CNT_W-1:0] group_size(input logic [DEG_W-1:0] deg);
    logic [DEG_W-1:0] deg_sat;
    logic [CNT_W-1:0] n;
    deg_sat = (deg > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg;
    n = CNT_W'(deg_sat) + CNT_W'(1);
    return n * n;
  endfunction

endpackage

@@ src/complex_cross_term_accumulator.sv @@
// Flow: a transaction is registered in the product stage, then pushed into the queue, and a
// group's last coefficient loads the result register and out_valid when it is popped.
// Throughput: one coefficient per cycle while in_stall is low, set by the single product
// stage and the one-entry-per-cycle accumulate; one result per (degree+1)^2 coefficients.
// Reset (synchronous, rst high): clears degree to 0, the group count, the queue,
// the accumulators and the output valid.
module complex_cross_term_accumulator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cct_pkg::PADDR_W-1:0]         paddr,
  input  logic [cct_pkg::PDATA_W-1:0]         pwdata,
  output logic [cct_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cct_pkg::DATA_W-1:0]   v_real,
  input  logic signed [cct_pkg::DATA_W-1:0]   v_imag,
  input  logic signed [cct_pkg::DATA_W-1:0]   d_real,
  input  logic signed [cct_pkg::DATA_W-1:0]   d_imag,
  input  logic signed [cct_pkg::DATA_W-1:0]   w_real,
  input  logic signed [cct_pkg::DATA_W-1:0]   w_imag,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cct_pkg::SUM_W-1:0]    vv_sum,
  output logic signed [cct_pkg::SUM_W-1:0]    dd_sum,
  output logic signed [cct_pkg::SUM_W-1:0]    ww_sum,
  output logic signed [cct_pkg::SUM_W-1:0]    vd_sum,
  output logic signed [cct_pkg::SUM_W-1:0]    vw_sum,
  output logic signed [cct_pkg::SUM_W-1:0]    dw_sum
);

  logic [cct_pkg::DEG_W-1:0] degree;
  logic [cct_pkg::CNT_W-1:0] group_size;
  logic                      cfg_write;
  logic                      sel_degree;
  logic                      push;
  logic                      pop;
  cct_pkg::cct_entry_t       push_entry;
  cct_pkg::cct_entry_t       head;
  cct_pkg::cct_qstat_t       qstat;

  // Register access
  assign pready     = 1'b1;
  assign sel_degree = (paddr[cct_pkg::REG_IDX_LSB] == cct_pkg::REG_DEGREE);
  assign cfg_write  = psel && penable && pwrite && pready;
  assign prdata     = sel_degree ? cct_pkg::PDATA_W'(degree) : '0;

  // Hold degree and its group size
  always_ff @(posedge clk) begin
    if (rst) begin
      degree     <= '0;
      group_size <= cct_pkg::group_size('0);
    end else if (cfg_write && sel_degree) begin
      degree     <= pwdata[cct_pkg::DEG_W-1:0];
      group_size <= cct_pkg::group_size(pwdata[cct_pkg::DEG_W-1:0]);
    end
  end

  cct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .group_size (group_size),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .v_real     (v_real),
    .v_imag     (v_imag),
    .d_real     (d_real),
    .d_imag     (d_imag),
    .w_real     (w_real),
    .w_imag     (w_imag),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  cct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  cct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .vv_sum    (vv_sum),
    .dd_sum    (dd_sum),
    .ww_sum    (ww_sum),
    .vd_sum    (vd_sum),
    .vw_sum    (vw_sum),
    .dw_sum    (dw_sum)
  );

endmodule

@@ src/cct_front.sv @@
module cct_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [cct_pkg::CNT_W-1:0]          group_size,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [cct_pkg::DATA_W-1:0]  v_real,
  input  logic signed [cct_pkg::DATA_W-1:0]  v_imag,
  input  logic signed [cct_pkg::DATA_W-1:0]  d_real,
  input  logic signed [cct_pkg::DATA_W-1:0]  d_imag,
  input  logic signed [cct_pkg::DATA_W-1:0]  w_real,
  input  logic signed [cct_pkg::DATA_W-1:0]  w_imag,
  input  cct_pkg::cct_qstat_t                qstat,
  output logic                               push,
  output cct_pkg::cct_entry_t                push_entry
);

  logic                              prod_valid;
  logic                              prod_last;
  logic [cct_pkg::CNT_W-1:0]         count;
  logic [cct_pkg::CNT_W-1:0]         count_next;
  logic                              last_next;
  logic                              accept;
  logic signed [cct_pkg::PROD_W-1:0] p_vv_r, p_vv_i, p_dd_r, p_dd_i, p_ww_r, p_ww_i;
  logic signed [cct_pkg::PROD_W-1:0] p_vd_r, p_vd_i, p_vw_r, p_vw_i, p_dw_r, p_dw_i;

  // Hold the input while the product stage cannot drain into the queue
  assign in_stall = prod_valid && qstat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = prod_valid && !qstat.full;

  // Classify the transaction: does it close the current group
  assign count_next = count + cct_pkg::CNT_W'(1);
  assign last_next  = (count_next >= group_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      count      <= '0;
    end else begin
      if (accept) begin
        prod_valid <= 1'b1;
        count      <= last_next ? '0 : count_next;
      end else if (push) begin
        prod_valid <= 1'b0;
      end
    end
  end

  // Product stage: twelve independent multiplies
  always_ff @(posedge clk) begin
    if (accept) begin
      prod_last <= last_next;
      p_vv_r    <= v_real * v_real;
      p_vv_i    <= v_imag * v_imag;
      p_dd_r    <= d_real * d_real;
      p_dd_i    <= d_imag * d_imag;
      p_ww_r    <= w_real * w_real;
      p_ww_i    <= w_imag * w_imag;
      p_vd_r    <= v_real * d_real;
      p_vd_i    <= v_imag * d_imag;
      p_vw_r    <= v_real * w_real;
      p_vw_i    <= v_imag * w_imag;
      p_dw_r    <= d_real * w_real;
      p_dw_i    <= d_imag * w_imag;
    end
  end

  // Fold real and imaginary products into one pair sum per term
  always_comb begin
    push_entry.last = prod_last;
    push_entry.vv   = {p_vv_r[cct_pkg::PROD_W-1], p_vv_r} + {p_vv_i[cct_pkg::PROD_W-1], p_vv_i};
    push_entry.dd   = {p_dd_r[cct_pkg::PROD_W-1], p_dd_r} + {p_dd_i[cct_pkg::PROD_W-1], p_dd_i};
    push_entry.ww   = {p_ww_r[cct_pkg::PROD_W-1], p_ww_r} + {p_ww_i[cct_pkg::PROD_W-1], p_ww_i};
    push_entry.vd   = {p_vd_r[cct_pkg::PROD_W-1], p_vd_r} + {p_vd_i[cct_pkg::PROD_W-1], p_vd_i};
    push_entry.vw   = {p_vw_r[cct_pkg::PROD_W-1], p_vw_r} + {p_vw_i[cct_pkg::PROD_W-1], p_vw_i};
    push_entry.dw   = {p_dw_r[cct_pkg::PROD_W-1], p_dw_r} + {p_dw_i[cct_pkg::PROD_W-1], p_dw_i};
  end

  // Group count stays below the largest group size
  assert property (@(posedge clk) disable iff (rst)
    count < cct_pkg::group_size(cct_pkg::DEG_W'(cct_pkg::MAX_DEGREE)))
    else $error("group count out of range");

endmodule

@@ src/cct_queue.sv @@
module cct_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cct_pkg::cct_entry_t push_entry,
  input  logic                pop,
  output cct_pkg::cct_entry_t head,
  output cct_pkg::cct_qstat_t qstat
);

  cct_pkg::cct_entry_t        slots [cct_pkg::QUEUE_DEPTH];
  logic [cct_pkg::QPTR_W-1:0] wr_ptr;
  logic [cct_pkg::QPTR_W-1:0] rd_ptr;
  logic [cct_pkg::QCNT_W-1:0] fill;

  assign qstat.full  = (fill == cct_pkg::QCNT_W'(cct_pkg::QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);
  assign head        = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + cct_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + cct_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + cct_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - cct_pkg::QCNT_W'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    fill <= cct_pkg::QCNT_W'(cct_pkg::QUEUE_DEPTH))
    else $error("queue occupancy overrun");

  assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full))
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty))
    else $error("pop from empty queue");

endmodule

@@ src/cct_back.sv @@
module cct_back (
  input  logic                              clk,
  input  logic                              rst,
  input  cct_pkg::cct_entry_t               head,
  input  cct_pkg::cct_qstat_t               qstat,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cct_pkg::SUM_W-1:0]  vv_sum,
  output logic signed [cct_pkg::SUM_W-1:0]  dd_sum,
  output logic signed [cct_pkg::SUM_W-1:0]  ww_sum,
  output logic signed [cct_pkg::SUM_W-1:0]  vd_sum,
  output logic signed [cct_pkg::SUM_W-1:0]  vw_sum,
  output logic signed [cct_pkg::SUM_W-1:0]  dw_sum
);

  localparam int EXT_W = cct_pkg::ACC_W - cct_pkg::PAIR_W;

  logic [cct_pkg::ACC_W-1:0] acc_vv, acc_dd, acc_ww, acc_vd, acc_vw, acc_dw;
  logic [cct_pkg::ACC_W-1:0] acc_vv_next, acc_dd_next, acc_ww_next;
  logic [cct_pkg::ACC_W-1:0] acc_vd_next, acc_vw_next, acc_dw_next;
  logic                      out_free;
  logic                      emit;

  // Take the head unless it closes a group and the result register is held
  assign out_free = !out_valid || !out_stall;
  assign pop      = !qstat.empty && (!head.last || out_free);
  assign emit     = pop && head.last;

  // Accumulate modulo 2^59
  assign acc_vv_next = acc_vv + {{EXT_W{head.vv[cct_pkg::PAIR_W-1]}}, head.vv};
  assign acc_dd_next = acc_dd + {{EXT_W{head.dd[cct_pkg::PAIR_W-1]}}, head.dd};
  assign acc_ww_next = acc_ww + {{EXT_W{head.ww[cct_pkg::PAIR_W-1]}}, head.ww};
  assign acc_vd_next = acc_vd + {{EXT_W{head.vd[cct_pkg::PAIR_W-1]}}, head.vd};
  assign acc_vw_next = acc_vw + {{EXT_W{head.vw[cct_pkg::PAIR_W-1]}}, head.vw};
  assign acc_dw_next = acc_dw + {{EXT_W{head.dw[cct_pkg::PAIR_W-1]}}, head.dw};

  // Update accumulators, clear them when a group ends
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vv <= '0;
      acc_dd <= '0;
      acc_ww <= '0;
      acc_vd <= '0;
      acc_vw <= '0;
      acc_dw <= '0;
    end else if (pop) begin
      if (head.last) begin
        acc_vv <= '0;
        acc_dd <= '0;
        acc_ww <= '0;
        acc_vd <= '0;
        acc_vw <= '0;
        acc_dw <= '0;
      end else begin
        acc_vv <= acc_vv_next;
        acc_dd <= acc_dd_next;
        acc_ww <= acc_ww_next;
        acc_vd <= acc_vd_next;
        acc_vw <= acc_vw_next;
        acc_dw <= acc_dw_next;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load result: power sums sign-extended, cross sums doubled
  always_ff @(posedge clk) begin
    if (emit) begin
      vv_sum <= {acc_vv_next[cct_pkg::ACC_W-1], acc_vv_next};
      dd_sum <= {acc_dd_next[cct_pkg::ACC_W-1], acc_dd_next};
      ww_sum <= {acc_ww_next[cct_pkg::ACC_W-1], acc_ww_next};
      vd_sum <= {acc_vd_next, 1'b0};
      vw_sum <= {acc_vw_next, 1'b0};
      dw_sum <= {acc_dw_next, 1'b0};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    emit |=> (acc_vv == '0) && (acc_vd == '0) && (acc_dw == '0))
    else $error("accumulators not cleared after group end");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !emit)
    else $error("result overwritten while held");

endmodule
